// File: design/ffha_pkg.sv
// ffha_pkg: shared types and constants for the first-fit heap allocator
// used by design/first_fit_heap_allocator.sv; no dependencies
package ffha_pkg;

  localparam int HEAP_WORDS_DEF  = 16384;
  localparam int CHUNK_BYTES_DEF = 4096;
  localparam int LIMIT_RESET     = 65536;

  localparam logic [31:0] ROOT_AT   = 32'd4;
  localparam logic [31:0] WSIZE     = 32'd4;
  localparam logic [31:0] DSIZE     = 32'd8;
  localparam logic [31:0] MIN_BLOCK = 32'd16;
  localparam logic [16:0] INIT_BYTES = 17'd24;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_NO_MEM    = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE, S_INIT_WR, S_GROW, S_GR_W1, S_GR_W2, S_GR_W3,
    S_MG_A, S_MG_B, S_MG_C, S_MG_D, S_MG_E, S_MG_F,
    S_MG_W1, S_MG_W2, S_MG_RD, S_MG_W3, S_MG_UL2, S_MG_PUSH, S_MG_END,
    S_FF_A, S_FF_B, S_FF_C,
    S_PL_A, S_PL_B, S_PL_C, S_PL_D, S_PL_E, S_PL_F, S_PL_PUSH, S_PL_END,
    S_FR_A, S_FR_B, S_FR_C,
    S_UL_A, S_UL_B, S_UL_C, S_UL_D,
    S_PU_A, S_PU_B, S_PU_C, S_PU_D, S_PU_E,
    S_DONE
  } state_t;

  // clear the tag bits of a boundary word
  function automatic logic [31:0] size_of(input logic [31:0] w);
    size_of = {w[31:3], 3'b000};
  endfunction

  // grow amount rounded up to an even number of words
  function automatic logic [17:0] grow_round(input logic [16:0] bytes);
    logic [15:0] words;
    words = {1'b0, bytes[16:2]};
    grow_round = {words + {15'd0, words[0]}, 2'b00};
  endfunction

endpackage

// File: design/first_fit_heap_allocator.sv
// first_fit_heap_allocator: boundary-tag heap with explicit lifo free list
// uses ffha_pkg; holds the heap word memory and its sequencer
// one item at a time; one memory read or write per sequencer step
// initialize writes the initial layout, then grows; release coalesces and pushes
// allocate walks the free list, then places the block or grows the heap
// rst clears control state, break and ready; heap memory is not cleared
module first_fit_heap_allocator #(
  parameter int HEAP_WORDS  = ffha_pkg::HEAP_WORDS_DEF,
  parameter int CHUNK_BYTES = ffha_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] request_bytes,
  input  logic [15:0] block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result_offset,
  output logic [1:0]  status,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);

  localparam int    AW         = $clog2(HEAP_WORDS);
  localparam int    SW         = $clog2(HEAP_WORDS + 1);
  localparam longint HEAP_BYTES = longint'(HEAP_WORDS) * 4;

  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] rdata;
  logic [31:0] rd_off, wr_off, wr_data;
  logic        we;

  ffha_pkg::state_t state, state_next, ret;

  logic [16:0] heap_limit, brk, lim_eff, need;
  logic        ready;
  logic [1:0]  op, st;
  logic [15:0] res;
  logic [17:0] gsz;
  logic [31:0] bp, pb, nb, sz, pbsz, pfsz, lk, lp, ln;
  logic        pa;
  logic [2:0]  idx;
  logic [SW-1:0] steps;

  logic        acc, grow_ok, ff_end, fits, split, out_free;
  logic [31:0] rd_m8, gsz32, need32;
  logic [16:0] need_calc, ext;
  logic [16:0] req_sum;

  assign lim_eff  = (longint'(heap_limit) < HEAP_BYTES) ? heap_limit : 17'(HEAP_BYTES);
  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != ffha_pkg::S_IDLE);
  assign rd_m8    = ffha_pkg::size_of(rdata);
  assign gsz32    = {14'd0, gsz};
  assign need32   = {15'd0, need};
  assign grow_ok  = ({2'b00, brk} + {1'b0, gsz}) <= {2'b00, lim_eff};
  assign ff_end   = (rdata == 32'd0) || (steps == SW'(HEAP_WORDS));
  assign fits     = rd_m8 >= need32;
  assign split    = (rd_m8 - need32) >= ffha_pkg::MIN_BLOCK;
  assign out_free = !out_valid || !out_stall;
  assign req_sum  = {1'b0, request_bytes} + 17'd15;
  assign need_calc = (request_bytes <= 16'd8) ? 17'd16 : {req_sum[16:3], 3'b000};
  assign ext      = (need > 17'(CHUNK_BYTES)) ? need : 17'(CHUNK_BYTES);

  // heap word memory, one read and one write port
  always_ff @(posedge clk) begin
    if (we) mem[wr_off[AW+1:2]] <= wr_data;
    rdata <= mem[rd_off[AW+1:2]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ffha_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    rd_off  = '0;
    wr_off  = '0;
    wr_data = '0;
    we      = 1'b0;
    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (acc) begin
          priority case (func)
            ffha_pkg::FUNC_INIT:
              state_next = (lim_eff < ffha_pkg::INIT_BYTES) ? ffha_pkg::S_DONE
                                                            : ffha_pkg::S_INIT_WR;
            ffha_pkg::FUNC_ALLOC:
              state_next = (!ready || request_bytes == 16'd0) ? ffha_pkg::S_DONE
                                                              : ffha_pkg::S_FF_A;
            ffha_pkg::FUNC_FREE:
              state_next = (!ready || block_offset == 16'd0) ? ffha_pkg::S_DONE
                                                             : ffha_pkg::S_FR_A;
            default: state_next = ffha_pkg::S_DONE;
          endcase
        end
      end
      ffha_pkg::S_INIT_WR: begin
        we = 1'b1;
        wr_off = {27'd0, idx, 2'b00};
        wr_data = (idx == 3'd3 || idx == 3'd4) ? 32'd9 : (idx == 3'd5) ? 32'd1 : 32'd0;
        if (idx == 3'd5) state_next = ffha_pkg::S_GROW;
      end
      ffha_pkg::S_GROW: state_next = grow_ok ? ffha_pkg::S_GR_W1 : ffha_pkg::S_DONE;
      ffha_pkg::S_GR_W1: begin
        we = 1'b1; wr_off = bp - ffha_pkg::WSIZE; wr_data = gsz32;
        state_next = ffha_pkg::S_GR_W2;
      end
      ffha_pkg::S_GR_W2: begin
        we = 1'b1; wr_off = bp + gsz32 - ffha_pkg::DSIZE; wr_data = gsz32;
        state_next = ffha_pkg::S_GR_W3;
      end
      ffha_pkg::S_GR_W3: begin
        // new epilogue
        we = 1'b1; wr_off = bp + gsz32 - ffha_pkg::WSIZE; wr_data = 32'd1;
        state_next = ffha_pkg::S_MG_A;
      end
      ffha_pkg::S_MG_A: begin
        rd_off = bp - ffha_pkg::WSIZE; state_next = ffha_pkg::S_MG_B;
      end
      ffha_pkg::S_MG_B: begin
        rd_off = bp - ffha_pkg::DSIZE; state_next = ffha_pkg::S_MG_C;
      end
      ffha_pkg::S_MG_C: begin
        rd_off = bp - rd_m8 - ffha_pkg::WSIZE; state_next = ffha_pkg::S_MG_D;
      end
      ffha_pkg::S_MG_D: begin
        rd_off = pb + rd_m8 - ffha_pkg::DSIZE; state_next = ffha_pkg::S_MG_E;
      end
      ffha_pkg::S_MG_E: begin
        rd_off = bp + sz - ffha_pkg::WSIZE; state_next = ffha_pkg::S_MG_F;
      end
      ffha_pkg::S_MG_F: begin
        priority if (pa && rdata[0]) begin
          state_next = ffha_pkg::S_PU_A;
        end else if (pa) begin
          we = 1'b1; wr_off = bp - ffha_pkg::WSIZE; wr_data = sz + rd_m8;
          state_next = ffha_pkg::S_MG_W1;
        end else if (rdata[0]) begin
          we = 1'b1; wr_off = bp + sz - ffha_pkg::DSIZE; wr_data = sz + pbsz;
          state_next = ffha_pkg::S_MG_W2;
        end else begin
          we = 1'b1; wr_off = pb - ffha_pkg::WSIZE; wr_data = sz + rd_m8 + pfsz;
          state_next = ffha_pkg::S_MG_RD;
        end
      end
      ffha_pkg::S_MG_W1: begin
        we = 1'b1; wr_off = bp + sz - ffha_pkg::DSIZE; wr_data = sz;
        state_next = ffha_pkg::S_UL_A;
      end
      ffha_pkg::S_MG_W2: begin
        we = 1'b1; wr_off = pb - ffha_pkg::WSIZE; wr_data = sz;
        state_next = ffha_pkg::S_UL_A;
      end
      ffha_pkg::S_MG_RD: begin
        rd_off = nb - ffha_pkg::WSIZE; state_next = ffha_pkg::S_MG_W3;
      end
      ffha_pkg::S_MG_W3: begin
        we = 1'b1; wr_off = nb + rd_m8 - ffha_pkg::DSIZE; wr_data = sz;
        state_next = ffha_pkg::S_UL_A;
      end
      ffha_pkg::S_MG_UL2:  state_next = ffha_pkg::S_UL_A;
      ffha_pkg::S_MG_PUSH: state_next = ffha_pkg::S_PU_A;
      ffha_pkg::S_MG_END:
        state_next = (op == ffha_pkg::FUNC_ALLOC) ? ffha_pkg::S_PL_A : ffha_pkg::S_DONE;
      ffha_pkg::S_FF_A: begin
        rd_off = ffha_pkg::ROOT_AT; state_next = ffha_pkg::S_FF_B;
      end
      ffha_pkg::S_FF_B: begin
        rd_off = rdata - ffha_pkg::WSIZE;
        state_next = ff_end ? ffha_pkg::S_GROW : ffha_pkg::S_FF_C;
      end
      ffha_pkg::S_FF_C: begin
        rd_off = bp;
        state_next = fits ? ffha_pkg::S_PL_A : ffha_pkg::S_FF_B;
      end
      ffha_pkg::S_PL_A: begin
        rd_off = bp - ffha_pkg::WSIZE; state_next = ffha_pkg::S_PL_B;
      end
      ffha_pkg::S_PL_B: begin
        we = 1'b1; wr_off = bp - ffha_pkg::WSIZE;
        if (split) begin
          wr_data = need32 | 32'd1; state_next = ffha_pkg::S_PL_C;
        end else begin
          wr_data = rd_m8 | 32'd1; state_next = ffha_pkg::S_PL_F;
        end
      end
      ffha_pkg::S_PL_C: begin
        we = 1'b1; wr_off = bp + need32 - ffha_pkg::DSIZE; wr_data = need32 | 32'd1;
        state_next = ffha_pkg::S_PL_D;
      end
      ffha_pkg::S_PL_D: begin
        we = 1'b1; wr_off = bp + need32 - ffha_pkg::WSIZE; wr_data = sz - need32;
        state_next = ffha_pkg::S_PL_E;
      end
      ffha_pkg::S_PL_E: begin
        we = 1'b1; wr_off = bp + sz - ffha_pkg::DSIZE; wr_data = sz - need32;
        state_next = ffha_pkg::S_UL_A;
      end
      ffha_pkg::S_PL_F: begin
        we = 1'b1; wr_off = bp + sz - ffha_pkg::DSIZE; wr_data = sz | 32'd1;
        state_next = ffha_pkg::S_UL_A;
      end
      ffha_pkg::S_PL_PUSH: state_next = ffha_pkg::S_PU_A;
      ffha_pkg::S_PL_END:  state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_FR_A: begin
        rd_off = bp - ffha_pkg::WSIZE; state_next = ffha_pkg::S_FR_B;
      end
      ffha_pkg::S_FR_B: begin
        we = 1'b1; wr_off = bp - ffha_pkg::WSIZE; wr_data = rd_m8;
        state_next = ffha_pkg::S_FR_C;
      end
      ffha_pkg::S_FR_C: begin
        we = 1'b1; wr_off = bp + sz - ffha_pkg::DSIZE; wr_data = sz;
        state_next = ffha_pkg::S_MG_A;
      end
      // unlink node lk
      ffha_pkg::S_UL_A: begin
        rd_off = lk + ffha_pkg::WSIZE; state_next = ffha_pkg::S_UL_B;
      end
      ffha_pkg::S_UL_B: begin
        rd_off = lk; state_next = ffha_pkg::S_UL_C;
      end
      ffha_pkg::S_UL_C: begin
        we = 1'b1; wr_off = lp; wr_data = rdata;
        state_next = (rdata == 32'd0) ? ret : ffha_pkg::S_UL_D;
      end
      ffha_pkg::S_UL_D: begin
        we = 1'b1; wr_off = ln + ffha_pkg::WSIZE; wr_data = lp;
        state_next = ret;
      end
      // push node lk at the list head
      ffha_pkg::S_PU_A: begin
        rd_off = ffha_pkg::ROOT_AT; state_next = ffha_pkg::S_PU_B;
      end
      ffha_pkg::S_PU_B: begin
        we = 1'b1; wr_off = ffha_pkg::ROOT_AT; wr_data = lk;
        state_next = ffha_pkg::S_PU_C;
      end
      ffha_pkg::S_PU_C: begin
        we = 1'b1; wr_off = lk + ffha_pkg::WSIZE; wr_data = ffha_pkg::ROOT_AT;
        state_next = ffha_pkg::S_PU_D;
      end
      ffha_pkg::S_PU_D: begin
        we = 1'b1; wr_off = lk; wr_data = ln;
        state_next = (ln == 32'd0) ? ret : ffha_pkg::S_PU_E;
      end
      ffha_pkg::S_PU_E: begin
        we = 1'b1; wr_off = ln + ffha_pkg::WSIZE; wr_data = lk;
        state_next = ret;
      end
      ffha_pkg::S_DONE: if (out_free) state_next = ffha_pkg::S_IDLE;
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= 17'(ffha_pkg::LIMIT_RESET);
      brk        <= '0;
      ready      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) heap_limit <= cfg_wr_data;
      if (state == ffha_pkg::S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)           out_valid <= 1'b0;
      if (acc && func == ffha_pkg::FUNC_INIT) begin
        ready <= 1'b0;
        brk   <= '0;
      end
      if (state == ffha_pkg::S_INIT_WR && idx == 3'd5) brk <= ffha_pkg::INIT_BYTES;
      if (state == ffha_pkg::S_GROW && grow_ok) brk <= 17'({1'b0, brk} + gsz);
      if (state == ffha_pkg::S_MG_END && op == ffha_pkg::FUNC_INIT) ready <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (acc) begin
          op  <= func;
          res <= '0;
          idx <= '0;
          need <= need_calc;
          bp  <= {16'd0, block_offset};
          priority case (func)
            ffha_pkg::FUNC_INIT:
              st <= (lim_eff < ffha_pkg::INIT_BYTES) ? ffha_pkg::ST_NO_MEM : ffha_pkg::ST_OK;
            ffha_pkg::FUNC_ALLOC:
              st <= !ready ? ffha_pkg::ST_NOT_READY :
                    (request_bytes == 16'd0) ? ffha_pkg::ST_ZERO : ffha_pkg::ST_OK;
            ffha_pkg::FUNC_FREE:
              st <= !ready ? ffha_pkg::ST_NOT_READY : ffha_pkg::ST_OK;
            default: st <= ffha_pkg::ST_OK;
          endcase
        end
      end
      ffha_pkg::S_INIT_WR: begin
        idx <= idx + 3'd1;
        gsz <= ffha_pkg::grow_round(17'(CHUNK_BYTES));
      end
      ffha_pkg::S_GROW: begin
        if (grow_ok) bp <= {15'd0, brk};
        else         st <= ffha_pkg::ST_NO_MEM;
      end
      ffha_pkg::S_MG_B: sz <= rd_m8;
      ffha_pkg::S_MG_C: pb <= bp - rd_m8;
      ffha_pkg::S_MG_D: pbsz <= rd_m8;
      ffha_pkg::S_MG_E: begin
        pa   <= rdata[0];
        pfsz <= rd_m8;
        nb   <= bp + sz;
      end
      ffha_pkg::S_MG_F: begin
        priority if (pa && rdata[0]) begin
          lk <= bp; ret <= ffha_pkg::S_MG_END;
        end else if (pa) begin
          sz <= sz + rd_m8;
        end else if (rdata[0]) begin
          sz <= sz + pbsz;
        end else begin
          sz <= sz + rd_m8 + pfsz;
        end
      end
      ffha_pkg::S_MG_W1: begin
        lk <= nb; ret <= ffha_pkg::S_MG_PUSH;
      end
      ffha_pkg::S_MG_W2: begin
        lk <= pb; bp <= pb; ret <= ffha_pkg::S_MG_PUSH;
      end
      ffha_pkg::S_MG_W3: begin
        lk <= pb; bp <= pb; ret <= ffha_pkg::S_MG_UL2;
      end
      ffha_pkg::S_MG_UL2: begin
        lk <= nb; ret <= ffha_pkg::S_MG_PUSH;
      end
      ffha_pkg::S_MG_PUSH: begin
        lk <= bp; ret <= ffha_pkg::S_MG_END;
      end
      ffha_pkg::S_FF_A: steps <= '0;
      ffha_pkg::S_FF_B: begin
        bp  <= rdata;
        gsz <= ffha_pkg::grow_round(ext);
      end
      ffha_pkg::S_FF_C: steps <= steps + SW'(1);
      ffha_pkg::S_PL_B: sz <= rd_m8;
      ffha_pkg::S_PL_E: begin
        nb <= bp + need32; lk <= bp; ret <= ffha_pkg::S_PL_PUSH;
      end
      ffha_pkg::S_PL_F: begin
        lk <= bp; ret <= ffha_pkg::S_PL_END;
      end
      ffha_pkg::S_PL_PUSH: begin
        lk <= nb; ret <= ffha_pkg::S_PL_END;
      end
      ffha_pkg::S_PL_END: res <= bp[15:0];
      ffha_pkg::S_FR_B: sz <= rd_m8;
      ffha_pkg::S_UL_B: lp <= rdata;
      ffha_pkg::S_UL_C: ln <= rdata;
      ffha_pkg::S_PU_B: ln <= rdata;
      ffha_pkg::S_DONE: begin
        if (out_free) begin
          result_offset <= res;
          status        <= st;
        end
      end
      default: ;
    endcase
  end

  a_ready_break: assert property (@(posedge clk) disable iff (rst)
    ready |-> brk >= ffha_pkg::INIT_BYTES)
    else $error("heap ready with break below the initial layout");

  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    acc && func == ffha_pkg::FUNC_ALLOC && !ready |=>
      state == ffha_pkg::S_DONE && st == ffha_pkg::ST_NOT_READY)
    else $error("allocate before init did not report not ready");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ffha_pkg::S_DONE)
    else $error("result beat raised outside the done step");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ffha_pkg::S_FF_C |-> steps < SW'(HEAP_WORDS))
    else $error("free-list walk ran past its bound");

endmodule

// File: sim/ffha_checker.sv
// ffha_checker: watches the allocator's input, output and config ports
// keeps its own copy of the heap, predicts every result beat and compares; uses ffha_pkg
`timescale 1ns / 100ps
module ffha_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] request_bytes,
  input  logic [15:0] block_offset,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] result_offset,
  input  logic [1:0]  status,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  output int          errors,
  output int          pending
);
  import ffha_pkg::*;

  localparam int NWORDS = HEAP_WORDS_DEF;
  localparam logic [31:0] CHUNK = CHUNK_BYTES_DEF;

  typedef struct {
    logic [15:0] offset;
    logic [1:0]  st;
  } alloc_result_t;

  logic [31:0]   heap_words [0:NWORDS-1];
  logic [31:0]   brk;
  logic          ready;
  logic [16:0]   limit_bytes;
  alloc_result_t result_q [$];

  function logic [31:0] word_at(input logic [31:0] a);
    return heap_words[a[15:2]];
  endfunction

  function void put_word(input logic [31:0] a, input logic [31:0] v);
    heap_words[a[15:2]] = v;
  endfunction

  function logic [31:0] size_at(input logic [31:0] a);
    return {word_at(a)[31:3], 3'b000};
  endfunction

  function logic [31:0] foot_of(input logic [31:0] bp);
    return bp + size_at(bp - WSIZE) - DSIZE;
  endfunction

  function logic [63:0] eff_limit();
    return (limit_bytes < NWORDS * 4) ? 64'(limit_bytes) : 64'(NWORDS * 4);
  endfunction

  function void list_remove(input logic [31:0] bp);
    logic [31:0] p, n;
    p = word_at(bp + WSIZE);
    n = word_at(bp);
    put_word(p, n);
    if (n != 0) put_word(n + WSIZE, p);
  endfunction

  function void list_push(input logic [31:0] bp);
    logic [31:0] first;
    first = word_at(ROOT_AT);
    put_word(ROOT_AT, bp);
    put_word(bp + WSIZE, ROOT_AT);
    put_word(bp, first);
    if (first != 0) put_word(first + WSIZE, bp);
  endfunction

  // four-way coalesce, merged block goes to the list head
  function logic [31:0] coalesce(input logic [31:0] bp_in);
    logic [31:0] bp, pb, nb, sz;
    logic pa, na;
    bp = bp_in;
    pb = bp - size_at(bp - DSIZE);
    nb = bp + size_at(bp - WSIZE);
    pa = word_at(foot_of(pb))[0];
    na = word_at(nb - WSIZE)[0];
    sz = size_at(bp - WSIZE);
    if (pa && na) begin
      list_push(bp);
      return bp;
    end
    if (pa) begin
      sz += size_at(nb - WSIZE);
      put_word(bp - WSIZE, sz);
      put_word(foot_of(bp), sz);
      list_remove(nb);
    end else if (na) begin
      sz += size_at(pb - WSIZE);
      put_word(foot_of(bp), sz);
      put_word(pb - WSIZE, sz);
      list_remove(pb);
      bp = pb;
    end else begin
      sz += size_at(nb - WSIZE) + size_at(foot_of(pb));
      put_word(pb - WSIZE, sz);
      put_word(foot_of(nb), sz);
      list_remove(pb);
      list_remove(nb);
      bp = pb;
    end
    list_push(bp);
    return bp;
  endfunction

  function logic extend_heap(input logic [31:0] bytes, output logic [31:0] bp);
    logic [31:0] words, sz;
    words = bytes >> 2;
    if (words[0]) words++;
    sz = words * 4;
    bp = 0;
    if (64'(brk) + 64'(sz) > eff_limit()) return 1'b0;
    bp = brk;
    brk += sz;
    put_word(bp - WSIZE, sz);
    put_word(bp + sz - DSIZE, sz);
    put_word(bp + sz - WSIZE, 32'd1);
    bp = coalesce(bp);
    return 1'b1;
  endfunction

  function logic [31:0] first_fit(input logic [31:0] need);
    logic [31:0] bp;
    int steps;
    bp = word_at(ROOT_AT);
    for (steps = 0; bp != 0 && steps < NWORDS; steps++) begin
      if (size_at(bp - WSIZE) >= need) return bp;
      bp = word_at(bp);
    end
    return 0;
  endfunction

  function void carve(input logic [31:0] bp, input logic [31:0] need);
    logic [31:0] total, rest, nb;
    total = size_at(bp - WSIZE);
    rest = total - need;
    if (rest >= MIN_BLOCK) begin
      put_word(bp - WSIZE, need | 1);
      put_word(foot_of(bp), need | 1);
      nb = bp + size_at(bp - WSIZE);
      put_word(nb - WSIZE, rest);
      put_word(foot_of(nb), rest);
      list_remove(bp);
      list_push(nb);
    end else begin
      put_word(bp - WSIZE, total | 1);
      put_word(foot_of(bp), total | 1);
      list_remove(bp);
    end
  endfunction

  function alloc_result_t predict_op(input logic [1:0] f, input logic [15:0] req,
                                     input logic [15:0] off);
    alloc_result_t r;
    logic [31:0] bp, need, ext, sz, o;
    r.offset = 0;
    r.st = ST_OK;
    o = {16'd0, off};
    if (f == FUNC_INIT) begin
      ready = 0;
      brk = 0;
      if (64'(INIT_BYTES) > eff_limit()) r.st = ST_NO_MEM;
      else begin
        put_word(0, 0); put_word(4, 0); put_word(8, 0);
        put_word(12, 9); put_word(16, 9); put_word(20, 1);
        brk = 32'(INIT_BYTES);
        if (extend_heap(CHUNK, bp)) ready = 1;
        else r.st = ST_NO_MEM;
      end
    end else if (f == FUNC_ALLOC) begin
      if (!ready) r.st = ST_NOT_READY;
      else if (req == 0) r.st = ST_ZERO;
      else begin
        need = (req <= 8) ? MIN_BLOCK : DSIZE * ((32'(req) + 15) / 8);
        bp = first_fit(need);
        if (bp != 0) begin
          carve(bp, need);
          r.offset = bp[15:0];
        end else begin
          ext = (need > CHUNK) ? need : CHUNK;
          if (extend_heap(ext, bp)) begin
            carve(bp, need);
            r.offset = bp[15:0];
          end else r.st = ST_NO_MEM;
        end
      end
    end else if (f == FUNC_FREE) begin
      if (!ready) r.st = ST_NOT_READY;
      else if (o != 0) begin
        sz = size_at(o - WSIZE);
        put_word(o - WSIZE, sz);
        put_word(foot_of(o), sz);
        void'(coalesce(o));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want, got;
    if (rst) begin
      for (int i = 0; i < NWORDS; i++) heap_words[i] = 0;
      brk = 0;
      ready = 0;
      limit_bytes = 17'(LIMIT_RESET);
      result_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_wr_en) limit_bytes = cfg_wr_data;
      if (out_valid && !out_stall) begin
        got.offset = result_offset;
        got.st = status;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat offset=%0d status=%0d",
                   $time, got.offset, got.st);
        end else begin
          want = result_q.pop_front();
          if (got.offset !== want.offset) begin
            errors++;
            $display("%0t: result_offset expected %0d actual %0d",
                     $time, want.offset, got.offset);
          end
          if (got.st !== want.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          end
        end
      end
      if (in_valid && !in_stall)
        result_q.push_back(predict_op(func, request_bytes, block_offset));
      pending = result_q.size();
    end
  end

endmodule

// File: sim/tb_first_fit_heap_allocator.sv
// tb_first_fit_heap_allocator: stimulus and verdict for the heap allocator
// depends on ffha_pkg, first_fit_heap_allocator and ffha_checker
`timescale 1ns / 100ps
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  func = FUNC_ALLOC;
  logic [15:0] request_bytes = 0;
  logic [15:0] block_offset = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] result_offset;
  logic [1:0]  status;
  logic        cfg_wr_en = 0;
  logic [16:0] cfg_wr_data = 0;
  int          errors, pending;

  logic [1:0]  sent_ops [$];
  logic [15:0] live_blocks [$];
  bit          quiet = 0;
  int          stall_left = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  first_fit_heap_allocator dut (.*);

  ffha_checker u_checker (.*);

  // receiver: random stall per beat, none while quiet
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        stall_left = quiet ? 0 : $urandom_range(0, 8);
        if (sent_ops.size() != 0 && sent_ops.pop_front() == FUNC_ALLOC &&
            status == ST_OK && result_offset != 0)
          live_blocks.push_back(result_offset);
      end else if (stall_left > 0) stall_left--;
      out_stall <= (stall_left != 0);
      if (in_valid && !in_stall) sent_ops.push_back(func);
    end
  end

  task automatic issue(input logic [1:0] f, input logic [15:0] req, input logic [15:0] off);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    request_bytes <= req;
    block_offset <= off;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0 || sent_ops.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic free_random(input bit skew);
    int k;
    logic [15:0] off;
    k = $urandom_range(0, live_blocks.size() - 1);
    off = live_blocks[k];
    live_blocks.delete(k);
    // low bits of the offset are ignored when the block forms word addresses
    if (skew) off = off | 16'($urandom_range(0, 3));
    issue(FUNC_FREE, 0, off);
  endtask

  task automatic restart_heap(input logic [16:0] lim);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 0;
    live_blocks.delete();
    issue(FUNC_INIT, 0, 0);
  endtask

  task automatic random_ops(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40 && live_blocks.size() != 0)
        free_random($urandom_range(0, 9) == 0);
      else if (pick < 45)
        issue($urandom_range(0, 1) ? FUNC_UNUSED : FUNC_FREE, 16'($urandom),
              $urandom_range(0, 1) ? 16'd0 : 16'($urandom));
      else if (pick < 50)
        issue(FUNC_ALLOC, 16'($urandom), 16'($urandom));
      else if (pick < 58)
        issue(FUNC_ALLOC, 16'($urandom_range(0, 8000)), 0);
      else
        issue(FUNC_ALLOC, 16'($urandom_range(1, 200)), 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // not ready, unused selector, then the basic cases after init
    issue(FUNC_ALLOC, 16'd16, 0);
    issue(FUNC_FREE, 0, 16'hFFFF);
    issue(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
    restart_heap(17'd65536);
    issue(FUNC_ALLOC, 0, 0);
    issue(FUNC_ALLOC, 1, 0);
    issue(FUNC_ALLOC, 8, 0);
    issue(FUNC_ALLOC, 9, 0);
    issue(FUNC_ALLOC, 100, 0);
    issue(FUNC_ALLOC, 16'hFFFF, 0);
    issue(FUNC_ALLOC, 5000, 0);
    issue(FUNC_FREE, 0, 0);
    drain();
    // the sender holds off here until every result is back
    while (live_blocks.size() != 0) free_random(0);
    issue(FUNC_ALLOC, 3000, 0);
    issue(FUNC_ALLOC, 60000, 0);

    restart_heap(17'd4120);
    issue(FUNC_ALLOC, 4000, 0);
    issue(FUNC_ALLOC, 4072, 0);
    issue(FUNC_ALLOC, 16, 0);
    random_ops(60);

    restart_heap(17'd65536);
    random_ops(170);
    restart_heap(17'd65535);
    random_ops(130);
    restart_heap(17'($urandom_range(4120, 65536)));
    random_ops(110);

    drain();
    if (errors == 0) $display("tb_first_fit_heap_allocator: PASS");
    else $display("tb_first_fit_heap_allocator: FAIL");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_first_fit_heap_allocator: FAIL");
    $finish;
  end

endmodule

// File: files.f
design/ffha_pkg.sv
design/first_fit_heap_allocator.sv
sim/ffha_checker.sv
sim/tb_first_fit_heap_allocator.sv
